FILE: rtl/sema_pkg.sv
// sema_pkg: widths, command codes and defaults shared by the memory access port
// used by the channel interfaces and by sized_endian_memory_access_top
`timescale 1ns / 1ps

package sema_pkg;

  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 64;
  localparam int SIZE_W   = 2;
  localparam int LIMIT_W  = 17;
  localparam int LEN_W    = 4;
  localparam int LANES    = 8;

  localparam int MEM_BYTES_DEF = 65536;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

endpackage

FILE: rtl/sema_req_if.sv
// sema_req_if: request channel (valid/ready plus one access word)
// depends on sema_pkg for field widths
`timescale 1ns / 1ps

interface sema_req_if;
  import sema_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] size_code;
  logic              big_endian;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, command, address, size_code, big_endian, write_data,
                  input ready);
  modport sink   (input valid, command, address, size_code, big_endian, write_data,
                  output ready);
endinterface

FILE: rtl/sema_rsp_if.sv
// sema_rsp_if: response channel (valid/ready plus one result word)
// depends on sema_pkg for field widths
`timescale 1ns / 1ps

interface sema_rsp_if;
  import sema_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              out_of_bounds;

  modport source (output valid, read_data, out_of_bounds, input ready);
  modport sink   (input valid, read_data, out_of_bounds, output ready);
endinterface

FILE: rtl/sized_endian_memory_access_top.sv
// sized_endian_memory_access_top: byte-addressed load/store port, 1/2/4/8 bytes,
// unaligned, little or big endian; depends on sema_pkg, sema_req_if, sema_rsp_if
`timescale 1ns / 1ps

// channel | dir | handshake     | payload
// req     | in  | valid/ready   | command, address, size_code, big_endian, write_data
// rsp     | out | valid/ready   | read_data, out_of_bounds
// cfg     | in  | cfg_we only   | cfg_wdata (memory_limit)
//
// one access per cycle sustained while rsp.ready holds; a result shows on rsp once its
// request has passed the input register, bank access register and result register
// the store is eight byte-wide banks, one port each, so an unaligned 8-byte
// access touches every bank exactly once in its cycle
// rst clears the valid flags and memory_limit only; store contents stay undefined
// until written, and there is no clearing pass
// a stall on rsp backs up through the three stages; each holds its word

module sized_endian_memory_access_top #(
  parameter int MEM_BYTES = sema_pkg::MEM_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sema_pkg::LIMIT_W-1:0] cfg_wdata,
  sema_req_if.sink                     req,
  sema_rsp_if.source                   rsp
);
  import sema_pkg::*;

  // rows per bank and row index width
  localparam int ROWS = (MEM_BYTES + LANES - 1) / LANES;
  localparam int RW   = $clog2(ROWS);
  localparam logic [ADDR_W:0] MEM_END = (ADDR_W + 1)'(MEM_BYTES);

  // config register
  logic [LIMIT_W-1:0] memory_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      memory_limit <= cfg_wdata;
    end
  end

  // stage 1: input register
  logic              s1_valid;
  logic              s1_cmd;
  logic [ADDR_W-1:0] s1_addr;
  logic [SIZE_W-1:0] s1_size;
  logic              s1_big;
  logic [DATA_W-1:0] s1_wdata;

  // stage 2: bank read data plus what assembly needs
  logic              s2_valid;
  logic              s2_cmd;
  logic              s2_oob;
  logic [2:0]        s2_lane0;
  logic [LEN_W-1:0]  s2_len;
  logic              s2_big;
  logic [7:0]        bank_q [LANES];

  // result register
  logic              o_valid;
  logic [DATA_W-1:0] o_rdata;
  logic              o_oob;

  // flow control, each stage moves when the one after it frees up
  logic out_free, adv2, s2_free, adv1, take;

  assign out_free  = !o_valid || rsp.ready;
  assign adv2      = s2_valid && out_free;
  assign s2_free   = !s2_valid || adv2;
  assign adv1      = s1_valid && s2_free;
  assign req.ready = !s1_valid || adv1;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (adv1) begin
        s1_valid <= 1'b0;
      end
      if (adv1) begin
        s2_valid <= 1'b1;
      end else if (adv2) begin
        s2_valid <= 1'b0;
      end
      if (adv2) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd   <= req.command;
      s1_addr  <= req.address;
      s1_size  <= req.size_code;
      s1_big   <= req.big_endian;
      s1_wdata <= req.write_data;
    end
  end

  // bounds check: first byte past the access against the saturated limit
  logic [LEN_W-1:0] s1_len;
  logic [ADDR_W:0]  s1_end;
  logic [ADDR_W:0]  eff_limit;
  logic             s1_oob;
  logic             s1_store;

  always_comb begin
    s1_len    = LEN_W'(1) << s1_size;
    s1_end    = {1'b0, s1_addr} + (ADDR_W + 1)'(s1_len);
    eff_limit = (ADDR_W + 1)'(memory_limit);
    if (eff_limit > MEM_END) begin
      eff_limit = MEM_END;
    end
    s1_oob   = s1_end > eff_limit;
    s1_store = (s1_cmd == CMD_WRITE) && !s1_oob;
  end

  // one bank per low address value; byte j of the access (memory order)
  // sits in bank (addr + j) mod 8, one row further on once it wraps past bank 7
  for (genvar g = 0; g < LANES; g++) begin : g_bank
    logic [7:0]       mem [ROWS];
    logic [2:0]       j;
    logic             act;
    logic [LEN_W-1:0] vi;
    logic [RW-1:0]    row;
    logic [7:0]       wbyte;
    logic             we;

    assign j   = 3'(g) - s1_addr[2:0];
    assign act = {1'b0, j} < s1_len;
    // value byte that lands in this bank
    assign vi  = s1_big ? (s1_len - LEN_W'(1) - {1'b0, j}) : {1'b0, j};
    assign row = s1_addr[RW+2:3] + RW'(3'(g) < s1_addr[2:0]);
    assign wbyte = s1_wdata[8*vi[2:0] +: 8];
    assign we    = adv1 && s1_store && act;

    always_ff @(posedge clk) begin
      if (we) begin
        mem[row] <= wbyte;
      end
      if (adv1) begin
        bank_q[g] <= mem[row];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_cmd   <= s1_cmd;
      s2_oob   <= s1_oob;
      s2_lane0 <= s1_addr[2:0];
      s2_len   <= s1_len;
      s2_big   <= s1_big;
    end
  end

  // gather bank bytes into the value, zero above the access size
  logic [DATA_W-1:0] rd_value;

  always_comb begin
    logic [LEN_W-1:0] jj;
    logic [2:0]       b;
    rd_value = '0;
    for (int i = 0; i < LANES; i++) begin
      jj = s2_big ? (s2_len - LEN_W'(1) - LEN_W'(i)) : LEN_W'(i);
      b  = s2_lane0 + jj[2:0];
      if (LEN_W'(i) < s2_len) begin
        rd_value[8*i +: 8] = bank_q[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      o_oob   <= s2_oob;
      o_rdata <= (s2_cmd == CMD_WRITE || s2_oob) ? '0 : rd_value;
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.read_data     = o_rdata;
  assign rsp.out_of_bounds = o_oob;

endmodule
